/* hdl/bfp_pkg.sv */
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants of the bitmap-font descriptor parser: the result
// beat layout, result kinds, descriptor magic bytes and the channel mask
// decode.
// ----------------------------------------------------------------------------
package bfp_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_GLYPH   = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_BAD_HDR = 2'd2;

   // Descriptor magic.
   localparam logic [7:0] MAGIC_0 = 8'h42;   // 'B'
   localparam logic [7:0] MAGIC_1 = 8'h4D;   // 'M'
   localparam logic [7:0] MAGIC_2 = 8'h46;   // 'F'

   // Block types.
   localparam logic [7:0] BLK_COMMON = 8'd2;
   localparam logic [7:0] BLK_CHARS  = 8'd4;

   localparam int unsigned RECORD_BYTES = 20;
   localparam logic [4:0]  RECORD_LAST  = 5'(RECORD_BYTES - 1);
   localparam logic [31:0] COMMON_MIN   = 32'd15;
   localparam logic [31:0] CODE_FLOOR   = 32'd255;
   localparam logic [31:0] CODE_CEIL    = 32'h0000_FFFF;

   // floor(h / 3) == (h * DIV3_MUL) >> DIV3_SHIFT for every 16-bit h.
   localparam logic [16:0] DIV3_MUL   = 17'd43691;
   localparam int unsigned DIV3_SHIFT = 17;

   // Result queue geometry.
   localparam int unsigned RES_DEPTH = 4;
   localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
   localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

   typedef struct packed {
      logic [1:0]         record_kind;
      logic [10:0]        glyph_slot;
      logic [31:0]        char_code;
      logic [15:0]        tex_left;
      logic [15:0]        tex_top;
      logic [15:0]        tex_right;
      logic [15:0]        tex_bottom;
      logic signed [15:0] pen_offset;
      logic signed [15:0] pen_advance;
      logic [15:0]        channel_mask;
      logic [15:0]        line_height;
   } bfp_result_type;

   function automatic logic [15:0] chan_mask(input logic [7:0] chnl);
      logic [15:0] mask;
      case (chnl)
         8'd1:    mask = 16'h000F;
         8'd2:    mask = 16'h00F0;
         8'd4:    mask = 16'h0F00;
         8'd8:    mask = 16'hF000;
         default: mask = 16'hFFFF;
      endcase
      return mask;
   endfunction

endpackage

/* hdl/bitmap_font_table_parser.sv */
// A result beat enters the result queue at the edge that accepts the byte causing it.
// Bytes are taken one per cycle while req_stall is low; only the last byte can
// cause two results, which leave in order through the four-entry result queue.
// req_stall rises while fewer than two queue entries are free.
// Reset (synchronous, active high) clears the parser state and the queue; the
// byte marked last also returns the parser to its reset state.
// ----------------------------------------------------------------------------
// bitmap_font_table_parser
// Parses a binary bitmap-font descriptor one byte per beat and emits a glyph
// beat per chars record (at most MAX_GLYPHS - 1) plus a summary (or bad-header) beat at end of file.
// ----------------------------------------------------------------------------
module bitmap_font_table_parser
   import bfp_pkg::*;
#(
   parameter int unsigned MAX_GLYPHS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_is_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_record_kind,
   output logic [10:0]        rsp_glyph_slot,
   output logic [31:0]        rsp_char_code,
   output logic [15:0]        rsp_tex_left,
   output logic [15:0]        rsp_tex_top,
   output logic [15:0]        rsp_tex_right,
   output logic [15:0]        rsp_tex_bottom,
   output logic signed [15:0] rsp_pen_offset,
   output logic signed [15:0] rsp_pen_advance,
   output logic [15:0]        rsp_channel_mask,
   output logic [15:0]        rsp_line_height
);

   localparam int unsigned GW = $clog2(MAX_GLYPHS);
   localparam logic [GW-1:0] GLYPH_LIMIT = GW'(MAX_GLYPHS - 1);

   localparam logic [2:0] PH_MAGIC  = 3'd0;
   localparam logic [2:0] PH_TYPE   = 3'd1;
   localparam logic [2:0] PH_SIZE   = 3'd2;
   localparam logic [2:0] PH_BODY   = 3'd3;
   localparam logic [2:0] PH_FAILED = 3'd4;

   logic [2:0]    phase_ff,   phase_in;
   logic [31:0]   cnt_ff,     cnt_in;
   logic [7:0]    kind_ff,    kind_in;
   logic [31:0]   len_ff,     len_in;
   logic [4:0]    idx_ff,     idx_in;
   logic [15:0]   height_ff,  height_in;
   logic [31:0]   tex_ff,     tex_in;
   logic [15:0]   largest_ff, largest_in;
   logic [GW-1:0] total_ff,   total_in;
   logic          failed_ff,  failed_in;
   logic [7:0]    rec_ff [RECORD_BYTES];

   logic [7:0]     rec_cur [RECORD_BYTES];
   logic           accept;
   logic           room_two;
   logic           glyph_take;
   logic           magic_bad;
   logic [31:0]    cnt_inc;
   logic [31:0]    glyph_id;
   logic [15:0]    gx, gy, gw, gh;
   logic [32:0]    div3_prod;
   logic [GW:0]    summary_slot;
   logic [31:0]    summary_code;
   logic [1:0]     push_cnt;
   bfp_result_type glyph_res, end_res, push0, push1, head;

   assign accept    = req_valid && !req_stall;
   assign req_stall = !room_two;
   assign cnt_inc   = cnt_ff + 32'd1;

   // The current byte is visible at its record position in the same cycle.
   always_comb begin
      for (int i = 0; i < RECORD_BYTES; i++) begin
         rec_cur[i] = (phase_ff == PH_BODY && idx_ff == 5'(i)) ? req_data_byte : rec_ff[i];
      end
   end

   assign glyph_id = {rec_cur[3], rec_cur[2], rec_cur[1], rec_cur[0]};
   assign gx       = {rec_cur[5], rec_cur[4]};
   assign gy       = {rec_cur[7], rec_cur[6]};
   assign gw       = {rec_cur[9], rec_cur[8]};
   assign gh       = {rec_cur[11], rec_cur[10]};

   assign magic_bad = (cnt_ff[1:0] == 2'd0 && req_data_byte != MAGIC_0) ||
                      (cnt_ff[1:0] == 2'd1 && req_data_byte != MAGIC_1) ||
                      (cnt_ff[1:0] == 2'd2 && req_data_byte != MAGIC_2);

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      kind_in    = kind_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      height_in  = height_ff;
      tex_in     = tex_ff;
      largest_in = largest_ff;
      total_in   = total_ff;
      failed_in  = failed_ff;
      glyph_take = 1'b0;
      case (phase_ff)
         PH_MAGIC: begin
            if (magic_bad) begin
               failed_in = 1'b1;
               phase_in  = PH_FAILED;
            end else if (cnt_ff[1:0] == 2'd3) begin
               phase_in = PH_TYPE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_inc;
            end
         end
         PH_TYPE: begin
            kind_in  = req_data_byte;
            len_in   = '0;
            cnt_in   = '0;
            idx_in   = '0;
            phase_in = PH_SIZE;
         end
         PH_SIZE: begin
            len_in = len_ff | ({24'd0, req_data_byte} << {cnt_ff[1:0], 3'b000});
            cnt_in = cnt_inc;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in   = '0;
               idx_in   = '0;
               phase_in = (len_in == 32'd0) ? PH_TYPE : PH_BODY;
            end
         end
         PH_BODY: begin
            cnt_in = cnt_inc;
            idx_in = (idx_ff == RECORD_LAST) ? 5'd0 : idx_ff + 5'd1;
            if (kind_ff == BLK_COMMON && len_ff >= COMMON_MIN && cnt_inc == COMMON_MIN) begin
               height_in = {rec_cur[1], rec_cur[0]};
               tex_in    = {rec_cur[7], rec_cur[6], rec_cur[5], rec_cur[4]};
            end
            if (kind_ff == BLK_CHARS && idx_ff == RECORD_LAST && total_ff < GLYPH_LIMIT) begin
               glyph_take = 1'b1;
               total_in   = total_ff + 1'b1;
               if (glyph_id > {16'd0, largest_ff} && glyph_id < CODE_CEIL) begin
                  largest_in = glyph_id[15:0];
               end
            end
            if (cnt_inc == len_ff) begin
               cnt_in   = '0;
               idx_in   = '0;
               phase_in = PH_TYPE;
            end
         end
         default: begin
         end
      endcase
   end

   // Result beats.
   assign div3_prod    = height_in * DIV3_MUL;
   assign summary_slot = {1'b0, total_in} + 1'b1;
   assign summary_code = ({16'd0, largest_in} < CODE_FLOOR) ? CODE_FLOOR
                                                             : {16'd0, largest_in};

   always_comb begin
      glyph_res.record_kind  = KIND_GLYPH;
      glyph_res.glyph_slot   = 11'(total_in);
      glyph_res.char_code    = glyph_id;
      glyph_res.tex_left     = gx;
      glyph_res.tex_top      = gy;
      glyph_res.tex_right    = gx + gw;
      glyph_res.tex_bottom   = gy + gh;
      glyph_res.pen_offset   = {rec_cur[13], rec_cur[12]};
      glyph_res.pen_advance  = {rec_cur[17], rec_cur[16]};
      glyph_res.channel_mask = chan_mask(rec_cur[19]);
      glyph_res.line_height  = height_ff;

      if (failed_in || phase_in == PH_MAGIC || phase_in == PH_FAILED) begin
         end_res             = '0;
         end_res.record_kind = KIND_BAD_HDR;
      end else begin
         end_res.record_kind  = KIND_SUMMARY;
         end_res.glyph_slot   = 11'(summary_slot);
         end_res.char_code    = summary_code;
         end_res.tex_left     = '0;
         end_res.tex_top      = '0;
         end_res.tex_right    = tex_in[15:0];
         end_res.tex_bottom   = tex_in[31:16];
         end_res.pen_offset   = '0;
         end_res.pen_advance  = div3_prod[DIV3_SHIFT +: 16];
         end_res.channel_mask = '0;
         end_res.line_height  = height_in;
      end

      push0    = glyph_take ? glyph_res : end_res;
      push1    = end_res;
      push_cnt = accept ? (2'(glyph_take) + 2'(req_is_last)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_is_last)) begin
         phase_ff   <= PH_MAGIC;
         cnt_ff     <= '0;
         kind_ff    <= '0;
         len_ff     <= '0;
         idx_ff     <= '0;
         height_ff  <= '0;
         tex_ff     <= '0;
         largest_ff <= '0;
         total_ff   <= '0;
         failed_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         kind_ff    <= kind_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
         height_ff  <= height_in;
         tex_ff     <= tex_in;
         largest_ff <= largest_in;
         total_ff   <= total_in;
         failed_ff  <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_BODY) begin
         rec_ff[idx_ff] <= req_data_byte;
      end
   end

   bfp_res_fifo u_res_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_data0 (push0),
      .push_data1 (push1),
      .room_two   (room_two),
      .pop_valid  (rsp_valid),
      .pop_stall  (rsp_stall),
      .pop_data   (head)
   );

   assign rsp_record_kind  = head.record_kind;
   assign rsp_glyph_slot   = head.glyph_slot;
   assign rsp_char_code    = head.char_code;
   assign rsp_tex_left     = head.tex_left;
   assign rsp_tex_top      = head.tex_top;
   assign rsp_tex_right    = head.tex_right;
   assign rsp_tex_bottom   = head.tex_bottom;
   assign rsp_pen_offset   = head.pen_offset;
   assign rsp_pen_advance  = head.pen_advance;
   assign rsp_channel_mask = head.channel_mask;
   assign rsp_line_height  = head.line_height;

   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && req_is_last) |=> (phase_ff == PH_MAGIC && total_ff == '0 && !failed_ff))
      else $error("parser not back in reset state after last beat");

   a_failed_phase: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (phase_ff == PH_FAILED))
      else $error("header failure outside failed phase");

   a_glyph_cap: assert property (@(posedge clock) disable iff (reset)
      total_ff <= GLYPH_LIMIT)
      else $error("glyph count beyond capacity");

   a_rsp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_record_kind == KIND_GLYPH || rsp_record_kind == KIND_SUMMARY ||
                     rsp_record_kind == KIND_BAD_HDR))
      else $error("result beat with unknown kind");

endmodule

/* hdl/bfp_res_fifo.sv */
// ----------------------------------------------------------------------------
// bfp_res_fifo
// Small result queue between the parser and the result channel. Takes up to
// two result beats per cycle and hands out one per cycle while pop_stall is low.
// ----------------------------------------------------------------------------
module bfp_res_fifo
   import bfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     push_cnt,
   input  bfp_result_type push_data0,
   input  bfp_result_type push_data1,
   output logic           room_two,
   output logic           pop_valid,
   input  logic           pop_stall,
   output bfp_result_type pop_data
);

   bfp_result_type        mem_ff [RES_DEPTH];
   logic [RES_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RES_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RES_CNT_W-1:0]  count_ff, count_in;
   logic [RES_PTR_W-1:0]  wr_ptr_nxt;
   logic                  pop;

   assign pop        = pop_valid && !pop_stall;
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign room_two   = (count_ff <= RES_CNT_W'(RES_DEPTH - 2));
   assign wr_ptr_nxt = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RES_PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + RES_PTR_W'(pop);
      count_in  = count_ff + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_nxt] <= push_data1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RES_CNT_W'(RES_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> (RES_CNT_W'(RES_DEPTH) - count_ff >= RES_CNT_W'(push_cnt)))
      else $error("result queue written without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push_cnt == 2'd0) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("result queue count did not drop on pop");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the font descriptor parser whole descriptor files, one byte per beat.
// Most files are well formed with random common, chars and other blocks; the
// rest are noise, corrupted magic, cut-off files and oversized blocks. A
// scoreboard predicts every glyph, summary and bad-header beat and checks the
// result channel against it while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import bfp_pkg::*;

   // A small table lets the capacity limit be reached by ordinary files.
   localparam int unsigned GLYPH_CAP    = 16;
   localparam int unsigned BYTE_TARGET  = 1050;
   localparam int unsigned IDLE_PERCENT = 31;

   typedef enum logic [2:0] {
      SEEK_MAGIC,
      READ_TYPE,
      READ_SIZE,
      READ_BODY,
      HDR_DEAD
   } parse_state_type;

   class font_scoreboard_type;
      parse_state_type state;
      logic [31:0]    count;
      logic [7:0]     kind;
      logic [31:0]    length;
      logic [7:0]     rec [RECORD_BYTES];
      logic [15:0]    height;
      logic [31:0]    tex_size;
      logic [15:0]    largest;
      logic [10:0]    total;
      logic           bad_magic;
      bfp_result_type expected_beats [$];
      int             mismatches;
      int             glyph_beats;
      int             summary_beats;
      int             bad_beats;

      function new();
         mismatches    = 0;
         glyph_beats   = 0;
         summary_beats = 0;
         bad_beats     = 0;
         clear();
      endfunction

      function void clear();
         state     = SEEK_MAGIC;
         count     = '0;
         kind      = '0;
         length    = '0;
         height    = '0;
         tex_size  = '0;
         largest   = '0;
         total     = '0;
         bad_magic = 1'b0;
         foreach (rec[i]) rec[i] = '0;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // Advances the parse by one accepted byte and queues the beats it causes.
      function void note_byte(logic [7:0] b, logic last);
         bfp_result_type r;
         logic [4:0]     idx;
         logic [31:0]    id;
         logic [15:0]    x;
         logic [15:0]    y;
         case (state)
            SEEK_MAGIC: begin
               if ((count == 0 && b != MAGIC_0) || (count == 1 && b != MAGIC_1) ||
                   (count == 2 && b != MAGIC_2)) begin
                  bad_magic = 1'b1;
                  state     = HDR_DEAD;
               end else if (count >= 3) begin
                  state = READ_TYPE;
                  count = '0;
               end else begin
                  count++;
               end
            end
            READ_TYPE: begin
               kind   = b;
               length = '0;
               count  = '0;
               state  = READ_SIZE;
            end
            READ_SIZE: begin
               length = length | (32'(b) << (8 * count[1:0]));
               count++;
               if (count >= 4) begin
                  count = '0;
                  state = (length == 0) ? READ_TYPE : READ_BODY;
               end
            end
            READ_BODY: begin
               idx      = 5'(count % RECORD_BYTES);
               rec[idx] = b;
               count++;
               if (kind == BLK_COMMON && length >= COMMON_MIN && count == COMMON_MIN) begin
                  height   = {rec[1], rec[0]};
                  tex_size = {rec[7], rec[6], rec[5], rec[4]};
               end
               if (kind == BLK_CHARS && idx == RECORD_LAST && total < GLYPH_CAP - 1) begin
                  id = {rec[3], rec[2], rec[1], rec[0]};
                  x  = {rec[5], rec[4]};
                  y  = {rec[7], rec[6]};
                  total++;
                  if (id > {16'h0, largest} && id < CODE_CEIL) largest = id[15:0];
                  r             = '0;
                  r.record_kind = KIND_GLYPH;
                  r.glyph_slot  = total;
                  r.char_code   = id;
                  r.tex_left    = x;
                  r.tex_top     = y;
                  r.tex_right   = x + {rec[9], rec[8]};
                  r.tex_bottom  = y + {rec[11], rec[10]};
                  r.pen_offset  = {rec[13], rec[12]};
                  r.pen_advance = {rec[17], rec[16]};
                  case (rec[RECORD_LAST])
                     8'd1:    r.channel_mask = 16'h000F;
                     8'd2:    r.channel_mask = 16'h00F0;
                     8'd4:    r.channel_mask = 16'h0F00;
                     8'd8:    r.channel_mask = 16'hF000;
                     default: r.channel_mask = 16'hFFFF;
                  endcase
                  r.line_height = height;
                  expected_beats.insert(expected_beats.size(), r);
               end
               if (count == length) begin
                  count = '0;
                  state = READ_TYPE;
               end
            end
            default: ;
         endcase

         if (last) begin
            r = '0;
            if (bad_magic || state == SEEK_MAGIC || state == HDR_DEAD) begin
               r.record_kind = KIND_BAD_HDR;
            end else begin
               r.record_kind = KIND_SUMMARY;
               r.glyph_slot  = total + 11'd1;
               r.char_code   = (largest < CODE_FLOOR[15:0]) ? CODE_FLOOR : {16'h0, largest};
               r.tex_right   = tex_size[15:0];
               r.tex_bottom  = tex_size[31:16];
               r.pen_advance = height / 16'd3;
               r.line_height = height;
            end
            expected_beats.insert(expected_beats.size(), r);
            clear();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_beat(bfp_result_type got);
         bfp_result_type want;
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: kind %0d", got.record_kind);
            mismatches++;
            return;
         end
         want = expected_beats.pop_front();
         case (want.record_kind)
            KIND_GLYPH:   glyph_beats++;
            KIND_SUMMARY: summary_beats++;
            default:      bad_beats++;
         endcase
         compare_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
         compare_field("glyph_slot", 32'(want.glyph_slot), 32'(got.glyph_slot));
         compare_field("char_code", want.char_code, got.char_code);
         compare_field("tex_left", 32'(want.tex_left), 32'(got.tex_left));
         compare_field("tex_top", 32'(want.tex_top), 32'(got.tex_top));
         compare_field("tex_right", 32'(want.tex_right), 32'(got.tex_right));
         compare_field("tex_bottom", 32'(want.tex_bottom), 32'(got.tex_bottom));
         compare_field("pen_offset", 32'(want.pen_offset), 32'(got.pen_offset));
         compare_field("pen_advance", 32'(want.pen_advance), 32'(got.pen_advance));
         compare_field("channel_mask", 32'(want.channel_mask), 32'(got.channel_mask));
         compare_field("line_height", 32'(want.line_height), 32'(got.line_height));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_is_last   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [1:0]  rsp_record_kind;
   logic [10:0] rsp_glyph_slot;
   logic [31:0] rsp_char_code;
   logic [15:0] rsp_tex_left;
   logic [15:0] rsp_tex_top;
   logic [15:0] rsp_tex_right;
   logic [15:0] rsp_tex_bottom;
   logic signed [15:0] rsp_pen_offset;
   logic signed [15:0] rsp_pen_advance;
   logic [15:0] rsp_channel_mask;
   logic [15:0] rsp_line_height;

   bfp_result_type      rsp_beat;
   font_scoreboard_type sb;
   logic [7:0]          file_bytes [$];
   logic                calm = 1'b0;
   int unsigned         bytes_sent = 0;
   int unsigned         files_sent = 0;

   always #2 clock = ~clock;

   bitmap_font_table_parser #(
      .MAX_GLYPHS(GLYPH_CAP)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_glyph_slot   (rsp_glyph_slot),
      .rsp_char_code    (rsp_char_code),
      .rsp_tex_left     (rsp_tex_left),
      .rsp_tex_top      (rsp_tex_top),
      .rsp_tex_right    (rsp_tex_right),
      .rsp_tex_bottom   (rsp_tex_bottom),
      .rsp_pen_offset   (rsp_pen_offset),
      .rsp_pen_advance  (rsp_pen_advance),
      .rsp_channel_mask (rsp_channel_mask),
      .rsp_line_height  (rsp_line_height)
   );

   assign rsp_beat = {rsp_record_kind, rsp_glyph_slot, rsp_char_code, rsp_tex_left,
                      rsp_tex_top, rsp_tex_right, rsp_tex_bottom, rsp_pen_offset,
                      rsp_pen_advance, rsp_channel_mask, rsp_line_height};

   // Outputs are sampled as they stood before the edge, then a new stall is drawn.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_beat(rsp_beat);
      rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
   end

   function automatic void append_byte(logic [7:0] b);
      file_bytes.insert(file_bytes.size(), b);
   endfunction

   function automatic void push_le32(logic [31:0] v);
      for (int i = 0; i < 4; i++) append_byte(v[8*i +: 8]);
   endfunction

   function automatic void push_random(int unsigned n);
      repeat (n) append_byte(8'($urandom));
   endfunction

   function automatic void add_common();
      int unsigned len;
      case ($urandom_range(19))
         0, 1, 2: len = $urandom_range(0, 14);
         3, 4, 5: len = $urandom_range(25, 60);
         default: len = $urandom_range(15, 24);
      endcase
      append_byte(BLK_COMMON);
      push_le32(32'(len));
      push_random(len);
   endfunction

   function automatic void add_chars();
      int unsigned nrec;
      int unsigned extra;
      logic [31:0] id;
      nrec  = ($urandom_range(9) == 0) ? $urandom_range(10, 18) : $urandom_range(0, 3);
      extra = ($urandom_range(3) == 0) ? $urandom_range(1, RECORD_BYTES - 1) : 0;
      append_byte(BLK_CHARS);
      push_le32(32'(nrec * RECORD_BYTES + extra));
      repeat (nrec) begin
         case ($urandom_range(4))
            0:       id = $urandom_range(0, 254);
            1:       id = $urandom_range(255, 2000);
            2:       id = $urandom;
            3:       id = CODE_CEIL;
            default: id = CODE_CEIL - 32'($urandom_range(1, 3));
         endcase
         push_le32(id);
         push_random(RECORD_BYTES - 5);
         case ($urandom_range(5))
            4:       append_byte(8'h00);
            5:       append_byte(8'($urandom));
            default: append_byte(8'd1 << $urandom_range(3));
         endcase
      end
      push_random(extra);
   endfunction

   function automatic void add_other(int unsigned len);
      logic [7:0] t;
      do t = 8'($urandom); while (t == BLK_COMMON || t == BLK_CHARS);
      append_byte(t);
      push_le32(32'(len));
      push_random(len);
   endfunction

   function automatic void build_file();
      int unsigned shape;
      int unsigned cut;
      file_bytes.delete();
      shape = $urandom_range(99);
      if (shape < 10) begin
         push_random($urandom_range(1, 8));
         return;
      end
      append_byte(MAGIC_0);
      append_byte(MAGIC_1);
      append_byte(MAGIC_2);
      append_byte(8'($urandom));
      if (shape < 16) begin
         cut = $urandom_range(2);
         file_bytes[cut] = file_bytes[cut] ^ 8'($urandom_range(1, 255));
      end
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(9))
            0, 1:    add_common();
            7, 8:    add_other($urandom_range(1, 10));
            9: begin
               // An empty block of any type goes straight on to the next type byte.
               append_byte(8'($urandom));
               push_le32('0);
            end
            default: add_chars();
         endcase
      end
      if ($urandom_range(9) == 0) begin
         // A block whose size runs far past the end of the file.
         append_byte(8'($urandom));
         push_le32({1'b1, 31'($urandom)});
         push_random($urandom_range(0, 45));
      end
      if ($urandom_range(99) < 15) begin
         cut = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_is_last   <= last;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      files_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      int  n;
      logic pressed;
      pressed = 1'b0;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed files: wrong first byte, header cut short, header only,
      // wrong middle magic byte, end inside a size field, end on an empty block.
      file_bytes = '{8'hFF};
      send_file();
      file_bytes = '{MAGIC_0, MAGIC_1};
      send_file();
      file_bytes = '{MAGIC_0, MAGIC_1, MAGIC_2, 8'hFF};
      send_file();
      file_bytes = '{MAGIC_0, 8'h00, MAGIC_2, 8'h03, 8'hFF};
      send_file();
      file_bytes = '{MAGIC_0, MAGIC_1, MAGIC_2, 8'h00, BLK_CHARS, 8'hFF};
      send_file();
      file_bytes = '{MAGIC_0, MAGIC_1, MAGIC_2, 8'h00, BLK_COMMON, 8'h00, 8'h00, 8'h00,
                     8'h00};
      send_file();
      wait_drained();

      while (bytes_sent < BYTE_TARGET) begin
         calm = (bytes_sent >= 350 && bytes_sent < 550);
         if (bytes_sent >= 700 && !pressed) begin
            pressed = 1'b1;
            wait_drained();
         end
         build_file();
         // The final file is cut off so the run stops near the byte target.
         while (file_bytes.size() > 1 && bytes_sent + file_bytes.size() > BYTE_TARGET)
            void'(file_bytes.pop_back());
         send_file();
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      for (n = 0; n < 5000 && sb.pending() != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected result beats never arrived", sb.pending());
         sb.mismatches += sb.pending();
      end

      $display("Sent %0d files in %0d byte beats.", files_sent, bytes_sent);
      $display("Checked %0d glyph, %0d summary and %0d bad-header beats.",
               sb.glyph_beats, sb.summary_beats, sb.bad_beats);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out.");
      $display("Mismatches found");
      $finish;
   end

endmodule
